@@ hdl/cna_pkg.sv @@
// Shared types, constants and arithmetic helpers for the complex-number ALU.
// No dependencies.
package cna_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int WIDE_BITS = PROD_BITS + 2;
    localparam int DVD_BITS  = PROD_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DVD_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_EQ   = 3'd4,
        OP_CONJ = 3'd5
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic                        dz;
        logic                        eq;
        logic signed [WORD_BITS-1:0] a_re;
        logic signed [WORD_BITS-1:0] a_im;
        logic signed [WORD_BITS-1:0] b_re;
        logic signed [WORD_BITS-1:0] b_im;
    } t_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
        logic                        eq;
        logic                        ovf;
        logic                        dz;
    } t_res;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 ovf;
    } t_sat;

    typedef struct packed {
        logic [PROD_BITS-1:0] rem;
        logic                 qbit;
    } t_dstep;

    typedef struct packed {
        logic front_valid;
        logic q_full;
    } t_front_stat;

    function automatic t_sat sat(input logic signed [WIDE_BITS-1:0] v);
        t_sat r;
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - WIDE_BITS'(1);
        r.ovf = 1'b1;
        if (v > hi) begin
            r.val = hi[WORD_BITS-1:0];
        end else if (v < lo) begin
            r.val = lo[WORD_BITS-1:0];
        end else begin
            r.val = v[WORD_BITS-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic t_dstep div_step(input logic [PROD_BITS-1:0] rem,
                                        input logic bit_in,
                                        input logic [PROD_BITS-1:0] den);
        t_dstep r;
        logic [PROD_BITS:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, den}) begin
            t      = t - {1'b0, den};
            r.qbit = 1'b1;
        end else begin
            r.qbit = 1'b0;
        end
        r.rem = t[PROD_BITS-1:0];
        return r;
    endfunction

    function automatic t_sat div_out(input logic [WORD_BITS:0] q, input logic big,
                                     input logic neg);
        t_sat r;
        logic [WORD_BITS:0] lim;
        logic [WORD_BITS:0] m;
        lim = neg ? {2'b01, {(WORD_BITS-1){1'b0}}} : {2'b00, {(WORD_BITS-1){1'b1}}};
        if (big || q > lim) begin
            m     = lim;
            r.ovf = 1'b1;
        end else begin
            m     = q;
            r.ovf = 1'b0;
        end
        if (neg) begin
            m = -m;
        end
        r.val = m[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

@@ hdl/cna_queue.sv @@
// Small first-word-fall-through queue of decoded items in flip-flops.
// Depends on cna_pkg.
module cna_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cna_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output cna_pkg::t_item o_item,
    output logic           o_empty
);

    cna_pkg::t_item               r_mem [cna_pkg::Q_DEPTH];
    logic [cna_pkg::Q_AW-1:0]     r_wr;
    logic [cna_pkg::Q_AW-1:0]     r_rd;
    logic [cna_pkg::Q_AW:0]       r_cnt;
    logic                         w_wr;
    logic                         w_rd;

    assign o_full  = (r_cnt == (cna_pkg::Q_AW+1)'(cna_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (cna_pkg::Q_AW+1)'(w_wr) - (cna_pkg::Q_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/cna_front.sv @@
// Input stage: registers each item and classifies it (equality, zero divisor).
// Depends on cna_pkg.
module cna_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic        [2:0]                    i_operation,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_a_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_a_im,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_b_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_b_im,
    input  logic                                 i_q_full,
    output logic                                 o_q_push,
    output cna_pkg::t_item                       o_item
);

    logic           r_valid;
    cna_pkg::t_item r_item;
    cna_pkg::t_item n_item;
    logic           w_acc;

    assign o_full   = r_valid && i_q_full;
    assign w_acc    = i_push && !o_full;
    assign o_q_push = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_item.op   = cna_pkg::t_op'(i_operation);
        n_item.eq   = (i_a_re == i_b_re) && (i_a_im == i_b_im);
        n_item.dz   = (i_b_re == '0) && (i_b_im == '0);
        n_item.a_re = i_a_re;
        n_item.a_im = i_a_im;
        n_item.b_re = i_b_re;
        n_item.b_im = i_b_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/cna_back.sv @@
// Execution: product stage, combine/saturate, bit-serial divider, result queue.
// Depends on cna_pkg.
module cna_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  cna_pkg::t_item                       i_item,
    output logic                                 o_q_pop,
    input  logic                                 i_pop,
    output logic                                 o_empty,
    output logic signed [cna_pkg::WORD_BITS-1:0] o_res_re,
    output logic signed [cna_pkg::WORD_BITS-1:0] o_res_im,
    output logic                                 o_is_equal,
    output logic                                 o_overflow,
    output logic                                 o_divide_by_zero
);

    localparam int PB = cna_pkg::PROD_BITS;
    localparam int WB = cna_pkg::WIDE_BITS;
    localparam int W  = cna_pkg::WORD_BITS;

    // product stage
    logic                 r_s1_valid;
    cna_pkg::t_item       r_s1;
    logic signed [PB-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;

    // divider
    logic                                r_busy;
    logic [cna_pkg::CNT_BITS-1:0]        r_cnt;
    logic [PB-1:0]                       r_den;
    logic [cna_pkg::DVD_BITS-1:0]        r_dvd_re, r_dvd_im;
    logic [PB-1:0]                       r_rem_re, r_rem_im;
    logic [W:0]                          r_q_re, r_q_im;
    logic                                r_big_re, r_big_im, r_neg_re, r_neg_im;
    cna_pkg::t_dstep                     w_st_re, w_st_im;
    logic [W:0]                          n_q_re, n_q_im;
    logic                                n_big_re, n_big_im;
    logic                                w_done;

    // result queue
    cna_pkg::t_res        r_out [cna_pkg::Q_DEPTH];
    logic [cna_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [cna_pkg::Q_AW:0]   r_ocnt;
    logic [cna_pkg::Q_AW+1:0] w_occ;

    logic          w_s1_adv, w_s1_load, w_start, w_wr, w_rd;
    cna_pkg::t_res w_s2, w_dres, w_wdata;
    cna_pkg::t_sat w_sr, w_si;
    logic signed [WB-1:0] w_nr, w_ni;
    logic [PB-1:0]        w_mr, w_mi, w_den;

    function automatic logic signed [WB-1:0] ext(input logic signed [PB-1:0] v);
        return {{(WB-PB){v[PB-1]}}, v};
    endfunction

    function automatic logic signed [WB-1:0] extw(input logic signed [W-1:0] v);
        return {{(WB-W){v[W-1]}}, v};
    endfunction

    assign w_occ     = (cna_pkg::Q_AW+2)'(r_ocnt) + (cna_pkg::Q_AW+2)'(r_s1_valid)
                     + (cna_pkg::Q_AW+2)'(r_busy);
    assign w_s1_adv  = r_s1_valid && !r_busy;
    assign w_s1_load = !i_q_empty && (!r_s1_valid || w_s1_adv)
                     && (w_occ < (cna_pkg::Q_AW+2)'(cna_pkg::Q_DEPTH));
    assign o_q_pop   = w_s1_load;
    assign w_start   = w_s1_adv && (r_s1.op == cna_pkg::OP_DIV) && !r_s1.dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1   <= i_item;
            r_p_rr <= PB'(i_item.a_re) * PB'(i_item.b_re);
            r_p_ii <= PB'(i_item.a_im) * PB'(i_item.b_im);
            r_p_ri <= PB'(i_item.a_re) * PB'(i_item.b_im);
            r_p_ir <= PB'(i_item.a_im) * PB'(i_item.b_re);
            r_sq_r <= PB'(i_item.b_re) * PB'(i_item.b_re);
            r_sq_i <= PB'(i_item.b_im) * PB'(i_item.b_im);
        end
    end

    // combine stage
    assign w_nr  = ext(r_p_rr) + ext(r_p_ii);
    assign w_ni  = ext(r_p_ir) - ext(r_p_ri);
    assign w_mr  = w_nr[WB-1] ? PB'(-w_nr) : PB'(w_nr);
    assign w_mi  = w_ni[WB-1] ? PB'(-w_ni) : PB'(w_ni);
    assign w_den = r_sq_r + r_sq_i;

    always_comb begin
        w_sr = '0;
        w_si = '0;
        w_s2 = '0;
        unique case (r_s1.op)
            cna_pkg::OP_ADD: begin
                w_sr = cna_pkg::sat(extw(r_s1.a_re) + extw(r_s1.b_re));
                w_si = cna_pkg::sat(extw(r_s1.a_im) + extw(r_s1.b_im));
            end
            cna_pkg::OP_SUB: begin
                w_sr = cna_pkg::sat(extw(r_s1.a_re) - extw(r_s1.b_re));
                w_si = cna_pkg::sat(extw(r_s1.a_im) - extw(r_s1.b_im));
            end
            cna_pkg::OP_MUL: begin
                w_sr = cna_pkg::sat((ext(r_p_rr) - ext(r_p_ii)) >>> cna_pkg::FRAC_BITS);
                w_si = cna_pkg::sat((ext(r_p_ri) + ext(r_p_ir)) >>> cna_pkg::FRAC_BITS);
            end
            cna_pkg::OP_DIV: begin
                w_s2.dz = r_s1.dz;
            end
            cna_pkg::OP_EQ: begin
                w_s2.eq = r_s1.eq;
            end
            cna_pkg::OP_CONJ: begin
                w_sr = cna_pkg::sat(extw(r_s1.a_re));
                w_si = cna_pkg::sat(-extw(r_s1.a_im));
            end
            default: begin
            end
        endcase
        w_s2.re  = w_sr.val;
        w_s2.im  = w_si.val;
        w_s2.ovf = w_sr.ovf | w_si.ovf;
    end

    // divider: one quotient bit per cycle for both parts
    assign w_st_re  = cna_pkg::div_step(r_rem_re, r_dvd_re[cna_pkg::DVD_BITS-1], r_den);
    assign w_st_im  = cna_pkg::div_step(r_rem_im, r_dvd_im[cna_pkg::DVD_BITS-1], r_den);
    assign n_q_re   = {r_q_re[W-1:0], w_st_re.qbit};
    assign n_q_im   = {r_q_im[W-1:0], w_st_im.qbit};
    assign n_big_re = r_big_re | r_q_re[W];
    assign n_big_im = r_big_im | r_q_im[W];
    assign w_done   = r_busy && (r_cnt == cna_pkg::CNT_BITS'(cna_pkg::DIV_STEPS - 1));

    always_comb begin
        cna_pkg::t_sat dr, di;
        dr          = cna_pkg::div_out(n_q_re, n_big_re, r_neg_re);
        di          = cna_pkg::div_out(n_q_im, n_big_im, r_neg_im);
        w_dres.re   = dr.val;
        w_dres.im   = di.val;
        w_dres.eq   = 1'b0;
        w_dres.ovf  = dr.ovf | di.ovf;
        w_dres.dz   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_start) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cnt    <= '0;
            r_den    <= w_den;
            r_dvd_re <= {w_mr, cna_pkg::FRAC_BITS'(0)};
            r_dvd_im <= {w_mi, cna_pkg::FRAC_BITS'(0)};
            r_rem_re <= '0;
            r_rem_im <= '0;
            r_q_re   <= '0;
            r_q_im   <= '0;
            r_big_re <= 1'b0;
            r_big_im <= 1'b0;
            r_neg_re <= w_nr[WB-1];
            r_neg_im <= w_ni[WB-1];
        end else if (r_busy) begin
            r_cnt    <= r_cnt + 1'b1;
            r_dvd_re <= r_dvd_re << 1;
            r_dvd_im <= r_dvd_im << 1;
            r_rem_re <= w_st_re.rem;
            r_rem_im <= w_st_im.rem;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
            r_big_re <= n_big_re;
            r_big_im <= n_big_im;
        end
    end

    // result queue
    assign w_wr    = w_done || (w_s1_adv && !w_start);
    assign w_wdata = w_done ? w_dres : w_s2;
    assign o_empty = (r_ocnt == '0);
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            r_ocnt <= r_ocnt + (cna_pkg::Q_AW+1)'(w_wr) - (cna_pkg::Q_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_out[r_wr] <= w_wdata;
        end
    end

    assign o_res_re         = r_out[r_rd].re;
    assign o_res_im         = r_out[r_rd].im;
    assign o_is_equal       = r_out[r_rd].eq;
    assign o_overflow       = r_out[r_rd].ovf;
    assign o_divide_by_zero = r_out[r_rd].dz;

endmodule

@@ hdl/complex_number_alu_top.sv @@
// Complex-number ALU top level: front stage, item queue and execution back end.
// Depends on cna_pkg, cna_front, cna_queue and cna_back.
// Add, subtract, multiply, equality and conjugate pass the front register,
// item queue and product stage and sustain one item per cycle while no divide
// runs and the result queue has room. Divide uses a shared restoring divider
// that produces one quotient bit per cycle for both parts over an 80-bit
// dividend (64 integer plus 16 fraction bits) while later items wait; a zero
// divisor skips the divider. Items keep order; up to four results wait for pop.
module complex_number_alu_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic        [2:0]                    i_operation,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_a_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_a_im,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_b_re,
    input  logic signed [cna_pkg::WORD_BITS-1:0] i_b_im,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [cna_pkg::WORD_BITS-1:0] o_res_re,
    output logic signed [cna_pkg::WORD_BITS-1:0] o_res_im,
    output logic                                 o_is_equal,
    output logic                                 o_overflow,
    output logic                                 o_divide_by_zero
);

    cna_pkg::t_item       w_f_item, w_q_item;
    logic                 w_q_full, w_f_valid;
    logic                 w_q_empty, w_q_pop;

    cna_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .i_q_full    (w_q_full),
        .o_q_push    (w_f_valid),
        .o_item      (w_f_item)
    );

    cna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty)
    );

    cna_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_item           (w_q_item),
        .o_q_pop          (w_q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_res_re         (o_res_re),
        .o_res_im         (o_res_im),
        .o_is_equal       (o_is_equal),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present after reset");
    a_rst_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");
    a_full_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_q_full && w_f_valid))
        else $error("full without a backed-up queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_empty |-> !w_q_pop)
        else $error("item taken from empty queue");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for complex_number_alu_top: directed, random and burst items
// are checked field by field against an in-bench predictor of the complex arithmetic.
// Depends on cna_pkg and the RTL of complex_number_alu_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [cna_pkg::WORD_BITS-1:0] re;
        logic [cna_pkg::WORD_BITS-1:0] im;
        logic                          eq;
        logic                          ovf;
        logic                          dz;
    } t_alu_res;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 push;
    logic                                 full;
    logic [2:0]                           i_operation;
    logic signed [cna_pkg::WORD_BITS-1:0] i_a_re;
    logic signed [cna_pkg::WORD_BITS-1:0] i_a_im;
    logic signed [cna_pkg::WORD_BITS-1:0] i_b_re;
    logic signed [cna_pkg::WORD_BITS-1:0] i_b_im;
    logic                                 empty;
    logic                                 pop;
    logic signed [cna_pkg::WORD_BITS-1:0] o_res_re;
    logic signed [cna_pkg::WORD_BITS-1:0] o_res_im;
    logic                                 o_is_equal;
    logic                                 o_overflow;
    logic                                 o_divide_by_zero;

    t_alu_res pending_results[$];
    int       mismatches;
    int       results_seen;
    int       items_sent;
    int       divides_sent;
    bit       no_idle;

    complex_number_alu_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_a_re           (i_a_re),
        .i_a_im           (i_a_im),
        .i_b_re           (i_b_re),
        .i_b_im           (i_b_im),
        .empty            (empty),
        .pop              (pop),
        .o_res_re         (o_res_re),
        .o_res_im         (o_res_im),
        .o_is_equal       (o_is_equal),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [cna_pkg::WORD_BITS-1:0] clamp_word(input t_wide v,
                                                                 inout logic ovf);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (cna_pkg::WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            ovf = 1'b1;
            return hi[cna_pkg::WORD_BITS-1:0];
        end else if (v < lo) begin
            ovf = 1'b1;
            return lo[cna_pkg::WORD_BITS-1:0];
        end
        return v[cna_pkg::WORD_BITS-1:0];
    endfunction

    function automatic t_alu_res predict_alu(input logic [2:0] op,
                                             input logic signed [cna_pkg::WORD_BITS-1:0] ar,
                                             input logic signed [cna_pkg::WORD_BITS-1:0] ai,
                                             input logic signed [cna_pkg::WORD_BITS-1:0] br,
                                             input logic signed [cna_pkg::WORD_BITS-1:0] bi);
        t_alu_res r;
        t_wide    xr, xi, yr, yi, den, num, mag, quo;
        logic     ovf;
        xr  = ar;
        xi  = ai;
        yr  = br;
        yi  = bi;
        ovf = 1'b0;
        r   = '{default: '0};
        case (op)
            cna_pkg::OP_ADD: begin
                r.re = clamp_word(xr + yr, ovf);
                r.im = clamp_word(xi + yi, ovf);
            end
            cna_pkg::OP_SUB: begin
                r.re = clamp_word(xr - yr, ovf);
                r.im = clamp_word(xi - yi, ovf);
            end
            cna_pkg::OP_MUL: begin
                r.re = clamp_word((xr * yr - xi * yi) >>> cna_pkg::FRAC_BITS, ovf);
                r.im = clamp_word((xr * yi + xi * yr) >>> cna_pkg::FRAC_BITS, ovf);
            end
            cna_pkg::OP_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num  = xr * yr + xi * yi;
                    mag  = (num < 0) ? -num : num;
                    quo  = (mag <<< cna_pkg::FRAC_BITS) / den;
                    r.re = clamp_word((num < 0) ? -quo : quo, ovf);
                    num  = xi * yr - xr * yi;
                    mag  = (num < 0) ? -num : num;
                    quo  = (mag <<< cna_pkg::FRAC_BITS) / den;
                    r.im = clamp_word((num < 0) ? -quo : quo, ovf);
                end
            end
            cna_pkg::OP_EQ: begin
                r.eq = (ar == br) && (ai == bi);
            end
            cna_pkg::OP_CONJ: begin
                r.re = ar;
                r.im = clamp_word(-xi, ovf);
            end
            default: begin
            end
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    task automatic send_item(input logic [2:0] op,
                             input logic signed [cna_pkg::WORD_BITS-1:0] ar,
                             input logic signed [cna_pkg::WORD_BITS-1:0] ai,
                             input logic signed [cna_pkg::WORD_BITS-1:0] br,
                             input logic signed [cna_pkg::WORD_BITS-1:0] bi);
        while (!no_idle && $urandom_range(99) < 34) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_a_re      <= ar;
        i_a_im      <= ai;
        i_b_re      <= br;
        i_b_im      <= bi;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_alu(op, ar, ai, br, bi));
        items_sent++;
        if (op == cna_pkg::OP_DIV) divides_sent++;
    endtask

    function automatic logic signed [cna_pkg::WORD_BITS-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
            2: return $signed($urandom_range(32'h03FF_FFFF)) - 32'sh0200_0000;
            3: begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0001_0000;
                    3: return -32'sh0001_0000;
                    default: return 32'sh0000_0001;
                endcase
            end
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        logic [2:0]                           op;
        logic signed [cna_pkg::WORD_BITS-1:0] ar, ai, br, bi;
        op = 3'($urandom_range(7));
        ar = rand_word();
        ai = rand_word();
        br = rand_word();
        bi = rand_word();
        if (op == cna_pkg::OP_EQ && $urandom_range(1)) begin
            br = ar;
            bi = ai;
        end
        send_item(op, ar, ai, br, bi);
    endtask

    task automatic test_directed();
        send_item(cna_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, -32'sh1);
        send_item(cna_pkg::OP_ADD, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                  -32'sh0001_0000);
        send_item(cna_pkg::OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, -32'sh1);
        send_item(cna_pkg::OP_SUB, 32'sh0005_0000, 32'sh0, 32'sh0002_8000, 32'sh0001_0000);
        send_item(cna_pkg::OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                  -32'sh0001_0000);
        send_item(cna_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000);
        send_item(cna_pkg::OP_MUL, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 32'sh0);
        send_item(cna_pkg::OP_MUL, -32'sh1, 32'sh0, 32'sh0000_0001, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh0006_0000, 32'sh0004_0000, 32'sh0002_0000, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh0001_0000, 32'sh0, 32'sh0003_0000, 32'sh0);
        send_item(cna_pkg::OP_DIV, -32'sh0001_0000, 32'sh0, 32'sh0003_0000, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0);
        send_item(cna_pkg::OP_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000);
        send_item(cna_pkg::OP_DIV, 32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0000_0001);
        send_item(cna_pkg::OP_EQ, 32'sh1234_5678, -32'sh5, 32'sh1234_5678, -32'sh5);
        send_item(cna_pkg::OP_EQ, 32'sh1234_5678, -32'sh5, 32'sh1234_5678, -32'sh4);
        send_item(cna_pkg::OP_EQ, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF);
        send_item(cna_pkg::OP_CONJ, 32'sh8000_0000, 32'sh8000_0000, 32'sh1, 32'sh1);
        send_item(cna_pkg::OP_CONJ, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0);
        send_item(3'd6, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 32'sh0);
        send_item(3'd7, -32'sh1, -32'sh1, -32'sh1, -32'sh1);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_burst(input int count);
        no_idle = 1'b1;
        repeat (count) send_random_item();
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_alu_res exp_res;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item");
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_res_re !== exp_res.re || o_res_im !== exp_res.im ||
                        o_is_equal !== exp_res.eq || o_overflow !== exp_res.ovf ||
                        o_divide_by_zero !== exp_res.dz) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp re=%h im=%h eq=%b ovf=%b dz=%b",
                                     exp_res.re, exp_res.im, exp_res.eq, exp_res.ovf,
                                     exp_res.dz);
                            $display("          got re=%h im=%h eq=%b ovf=%b dz=%b",
                                     o_res_re, o_res_im, o_is_equal, o_overflow,
                                     o_divide_by_zero);
                        end
                    end
                end
            end
            pop <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_operation = '0;
        i_a_re      = '0;
        i_a_im      = '0;
        i_b_re      = '0;
        i_b_im      = '0;
        no_idle     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(850);
        test_burst(180);
        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Checked %0d results from %0d items (%0d divides),",
                 results_seen, items_sent, divides_sent);
        $display("all opcodes incl. unused, with random stalls on both sides.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/cna_pkg.sv
hdl/cna_queue.sv
hdl/cna_front.sv
hdl/cna_back.sv
hdl/complex_number_alu_top.sv
sim/testbench.sv
